// File: hw/rtl/calje_pkg.sv
package calje_pkg;

    // opcodes with a meaning of their own
    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_JR    = 8'h18;
    localparam logic [7:0] OP_JR_NZ = 8'h20;
    localparam logic [7:0] OP_JR_Z  = 8'h28;
    localparam logic [7:0] OP_JR_NC = 8'h30;
    localparam logic [7:0] OP_JR_C  = 8'h38;
    localparam logic [7:0] OP_HALT  = 8'h76;

    // opcode group prefixes
    localparam logic [1:0] GRP_LD  = 2'b01;
    localparam logic [2:0] GRP_ALU = 3'b100;

    // operand codes in the opcode fields
    localparam logic [2:0] OPND_MEM = 3'd6;
    localparam logic [2:0] OPND_A   = 3'd7;

    // register file indexes
    localparam int unsigned GP_DEPTH = 7;
    localparam logic [2:0] IDX_H = 3'd4;
    localparam logic [2:0] IDX_L = 3'd5;
    localparam logic [2:0] IDX_A = 3'd6;

    // flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] flags_t;

    typedef struct packed {
        logic [7:0]        mode;
        logic signed [7:0] rel_offset;
        logic [7:0]        mem_data;
        logic [15:0]       pc_after;
    } instr_t;

    typedef struct packed {
        logic [7:0]  acc_value;
        logic [3:0]  flag_bits;
        logic [15:0] hl_address;
        logic        mem_write;
        logic [7:0]  mem_write_data;
        logic        jump_taken;
        logic [15:0] jump_target;
        logic        fault;
    } result_t;

    // operand code to register file index, memory code is not a register
    function automatic logic [2:0] reg_idx(input logic [2:0] code);
        reg_idx = (code == OPND_A) ? IDX_A : code;
    endfunction

endpackage

// File: hw/rtl/calje_if.sv
// instruction request channel
interface calje_in_if;
    import calje_pkg::*;

    logic              valid;
    logic              ready;
    logic [7:0]        mode;
    logic signed [7:0] rel_offset;
    logic [7:0]        mem_data;
    logic [15:0]       pc_after;

    modport source (
        output valid, mode, rel_offset, mem_data, pc_after,
        input  ready
    );

    modport sink (
        input  valid, mode, rel_offset, mem_data, pc_after,
        output ready
    );
endinterface

// result request channel
interface calje_out_if;
    import calje_pkg::*;

    logic        valid;
    logic        ready;
    logic [7:0]  acc_value;
    logic [3:0]  flag_bits;
    logic [15:0] hl_address;
    logic        mem_write;
    logic [7:0]  mem_write_data;
    logic        jump_taken;
    logic [15:0] jump_target;
    logic        fault;

    modport source (
        output valid, acc_value, flag_bits, hl_address, mem_write, mem_write_data,
               jump_taken, jump_target, fault,
        input  ready
    );

    modport sink (
        input  valid, acc_value, flag_bits, hl_address, mem_write, mem_write_data,
               jump_taken, jump_target, fault,
        output ready
    );
endinterface

// File: hw/rtl/cpu_alu_load_jump_execute_unit.sv
// an accepted request goes through the input and output registers to become its
// result request; throughput: one instruction per cycle unless the result
// stalls; the execute stage is one register file read, one 8-bit add or
// subtract and one 16-bit target add, then write-back; a stalled result holds
// in the output register while one more request waits in the input register;
// reset: B, C, D, E, H, L, A and the flags clear to zero, both stages empty
module cpu_alu_load_jump_execute_unit
    import calje_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    calje_in_if.sink         instr,
    calje_out_if.source      result
);

    // pipeline registers
    logic    item_valid_reg;
    instr_t  item_reg;
    logic    res_valid_reg;
    result_t res_reg;

    // architectural state
    byte_t  gp_reg  [GP_DEPTH];
    byte_t  gp_next [GP_DEPTH];
    flags_t flag_reg;
    flags_t flag_next;

    logic    advance;
    logic    exec;
    result_t res_next;

    // execute stage signals
    logic [7:0] op;
    logic [2:0] src_code;
    logic [2:0] dst_code;
    byte_t      src_val;
    byte_t      acc;
    logic       cin;
    logic       is_jr;
    logic       is_ld;
    logic       is_alu;
    logic       cond;
    logic [8:0] full_sum;
    logic [4:0] half_sum;
    logic [15:0] hl;
    logic [15:0] target;

    // handshake
    assign advance     = !res_valid_reg || result.ready;
    assign exec        = item_valid_reg && advance;
    assign instr.ready = !item_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (instr.ready)
        begin
            item_valid_reg <= instr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr.valid && instr.ready)
        begin
            item_reg.mode       <= instr.mode;
            item_reg.rel_offset <= instr.rel_offset;
            item_reg.mem_data   <= instr.mem_data;
            item_reg.pc_after   <= instr.pc_after;
        end
    end

    // decode and operand read
    always_comb
    begin
        op       = item_reg.mode;
        src_code = op[2:0];
        dst_code = op[5:3];
        acc      = gp_reg[IDX_A];
        hl       = {gp_reg[IDX_H], gp_reg[IDX_L]};
        src_val  = (src_code == OPND_MEM) ? item_reg.mem_data : gp_reg[reg_idx(src_code)];
        is_jr    = (op == OP_JR) || (op == OP_JR_NZ) || (op == OP_JR_Z)
                || (op == OP_JR_NC) || (op == OP_JR_C);
        is_ld    = (op[7:6] == GRP_LD) && (op != OP_HALT);
        is_alu   = (op[7:5] == GRP_ALU);
        cin      = op[3] & flag_reg[FLAG_C];
        target   = item_reg.pc_after
                 + {{8{item_reg.rel_offset[7]}}, item_reg.rel_offset};
    end

    // jump condition
    always_comb
    begin
        case (op)
            OP_JR_NZ: cond = !flag_reg[FLAG_Z];
            OP_JR_Z:  cond = flag_reg[FLAG_Z];
            OP_JR_NC: cond = !flag_reg[FLAG_C];
            OP_JR_C:  cond = flag_reg[FLAG_C];
            default:  cond = 1'b1;
        endcase
    end

    // adder, bit 4 of op picks subtract, top bits give carry or borrow
    always_comb
    begin
        if (op[4])
        begin
            full_sum = {1'b0, acc} - {1'b0, src_val} - {8'd0, cin};
            half_sum = {1'b0, acc[3:0]} - {1'b0, src_val[3:0]} - {4'd0, cin};
        end
        else
        begin
            full_sum = {1'b0, acc} + {1'b0, src_val} + {8'd0, cin};
            half_sum = {1'b0, acc[3:0]} + {1'b0, src_val[3:0]} + {4'd0, cin};
        end
    end

    // state update and result
    always_comb
    begin
        for (int i = 0; i < GP_DEPTH; i++)
        begin
            gp_next[i] = gp_reg[i];
        end
        flag_next                = flag_reg;
        res_next.hl_address      = hl;
        res_next.mem_write       = 1'b0;
        res_next.mem_write_data  = 8'd0;
        res_next.jump_taken      = 1'b0;
        res_next.jump_target     = 16'd0;
        res_next.fault           = 1'b0;

        if (op == OP_NOP)
        begin
            // nothing changes
        end
        else if (is_jr)
        begin
            if (cond)
            begin
                res_next.jump_taken  = 1'b1;
                res_next.jump_target = target;
            end
        end
        else if (is_ld)
        begin
            if (dst_code == OPND_MEM)
            begin
                res_next.mem_write      = 1'b1;
                res_next.mem_write_data = src_val;
            end
            else
            begin
                gp_next[reg_idx(dst_code)] = src_val;
            end
        end
        else if (is_alu)
        begin
            gp_next[IDX_A]    = full_sum[7:0];
            flag_next[FLAG_Z] = (full_sum[7:0] == 8'd0);
            flag_next[FLAG_N] = op[4];
            flag_next[FLAG_H] = half_sum[4];
            flag_next[FLAG_C] = full_sum[8];
        end
        else
        begin
            res_next.fault = 1'b1;
        end

        res_next.acc_value = gp_next[IDX_A];
        res_next.flag_bits = flag_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GP_DEPTH; i++)
            begin
                gp_reg[i] <= 8'd0;
            end
            flag_reg <= 4'd0;
        end
        else if (exec)
        begin
            for (int i = 0; i < GP_DEPTH; i++)
            begin
                gp_reg[i] <= gp_next[i];
            end
            flag_reg <= flag_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.acc_value      = res_reg.acc_value;
    assign result.flag_bits      = res_reg.flag_bits;
    assign result.hl_address     = res_reg.hl_address;
    assign result.mem_write      = res_reg.mem_write;
    assign result.mem_write_data = res_reg.mem_write_data;
    assign result.jump_taken     = res_reg.jump_taken;
    assign result.jump_target    = res_reg.jump_target;
    assign result.fault          = res_reg.fault;

endmodule

// File: hw/rtl/calje_checker.sv
module calje_checker
    import calje_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  acc_value,
    input logic [3:0]  flag_bits,
    input logic        mem_write,
    input logic [7:0]  mem_write_data,
    input logic        jump_taken,
    input logic [15:0] jump_target,
    input logic        fault
);

    // a stalled result holds its accumulator, flags and jump target
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(acc_value)
            && $stable(flag_bits) && $stable(jump_target))
    else $error("stalled result changed");

    // an accepted request passes the input register and reaches the output when the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("result missing after request");

    // a fault has no side effects
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault |-> !mem_write && !jump_taken && jump_target == 16'd0)
    else $error("fault with side effect");

    // store and jump are exclusive, idle payload fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(mem_write && jump_taken)
            && (mem_write || mem_write_data == 8'd0)
            && (jump_taken || jump_target == 16'd0))
    else $error("inconsistent store or jump fields");

endmodule

bind cpu_alu_load_jump_execute_unit calje_checker u_calje_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (instr.valid),
    .in_ready       (instr.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .acc_value      (result.acc_value),
    .flag_bits      (result.flag_bits),
    .mem_write      (result.mem_write),
    .mem_write_data (result.mem_write_data),
    .jump_taken     (result.jump_taken),
    .jump_target    (result.jump_target),
    .fault          (result.fault)
);
